// ----- design/eesa_pkg.sv -----
// shared types, limits and helpers for the element stiffness accumulator
// no dependencies
package eesa_pkg;

	localparam int DEF_MAX_NODES = 16;
	localparam int CFG_W = 32;
	localparam int VAL_W = 48;
	localparam int MX_W = 50;

	typedef enum logic [0:0] {
		CFG_LAMBDA = 1'b0,
		CFG_MU     = 1'b1
	} cfg_idx_t;

	localparam logic signed [VAL_W-1:0] POS_LIM = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] NEG_LIM = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic sat;
	} sat_val_t;

	typedef struct packed {
		logic signed [MX_W-1:0] x;
		logic signed [CFG_W-1:0] c;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [VAL_W-1:0] val;
		logic sat;
	} mul_rsp_t;

	function automatic sat_val_t clip48(input logic signed [MX_W-1:0] v);
		sat_val_t r;
		if (v > MX_W'(POS_LIM)) begin
			r.val = POS_LIM;
			r.sat = 1'b1;
		end else if (v < MX_W'(NEG_LIM)) begin
			r.val = NEG_LIM;
			r.sat = 1'b1;
		end else begin
			r.val = v[VAL_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- design/eesa_mulq.sv -----
// four-stage scaled multiply: round(x*c/2^16) half away from zero, clipped to 48 bits
// depends on eesa_pkg
module eesa_mulq (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  eesa_pkg::mul_req_t req,
	output eesa_pkg::mul_rsp_t rsp
);
	import eesa_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic [MX_W-1:0] m_s1, m_s2;
	logic [CFG_W-1:0] n_s1, n_s2;
	logic [63:0] lo_s2, lo_s3;
	logic [MX_W-1:0] hi_s3;
	logic [64:0] lo_rnd;
	logic [MX_W-1:0] q;
	sat_val_t res;
	logic done_q;
	logic signed [VAL_W-1:0] val_q;
	logic sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= req.x[MX_W-1] ^ req.c[CFG_W-1];
		m_s1 <= req.x[MX_W-1] ? MX_W'(-req.x) : MX_W'(req.x);
		n_s1 <= req.c[CFG_W-1] ? CFG_W'(-req.c) : CFG_W'(req.c);
		neg_s2 <= neg_s1;
		m_s2 <= m_s1;
		n_s2 <= n_s1;
		lo_s2 <= 64'(m_s1[31:0] * n_s1);
		neg_s3 <= neg_s2;
		lo_s3 <= lo_s2;
		hi_s3 <= MX_W'(m_s2[MX_W-1:32] * n_s2);
		val_q <= res.val;
		sat_q <= res.sat;
	end

	always_comb begin
		lo_rnd = 65'(lo_s3) + 65'h8000;
		q = MX_W'({hi_s3[31:0], 16'b0}) + MX_W'(lo_rnd[64:16]);
		res.val = '0;
		res.sat = 1'b0;
		if (|hi_s3[MX_W-1:32]) begin
			res.val = neg_s3 ? NEG_LIM : POS_LIM;
			res.sat = 1'b1;
		end else if (neg_s3) begin
			if (q > MX_W'({1'b1, {(VAL_W-1){1'b0}}})) begin
				res.val = NEG_LIM;
				res.sat = 1'b1;
			end else begin
				res.val = VAL_W'(-q);
			end
		end else begin
			if (q > MX_W'(POS_LIM)) begin
				res.val = POS_LIM;
				res.sat = 1'b1;
			end else begin
				res.val = q[VAL_W-1:0];
			end
		end
	end

	assign rsp = {done_q, val_q, sat_q};

endmodule

// ----- design/elastic_element_stiffness_accum.sv -----
// isotropic linear-elastic element stiffness block, set or accumulated into a block store
// one item at a time, through the shared four-stage multiply unit issued 39 times per item;
// busy stays high meanwhile
// the result is shown for one cycle with done and cannot be held off
// reset clears control and the Lame registers; the block store is undefined until set
// depends on eesa_pkg and eesa_mulq
module elastic_element_stiffness_accum #(
	parameter int MAX_NODES = eesa_pkg::DEF_MAX_NODES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  eesa_pkg::cfg_idx_t cfg_index,
	input  logic signed [eesa_pkg::CFG_W-1:0] cfg_data,
	input  logic start,
	output logic busy,
	input  logic cmd,
	input  logic [3:0] row_node,
	input  logic [3:0] col_node,
	input  logic signed [31:0] grad_row_x,
	input  logic signed [31:0] grad_row_y,
	input  logic signed [31:0] grad_row_z,
	input  logic signed [31:0] grad_col_x,
	input  logic signed [31:0] grad_col_y,
	input  logic signed [31:0] grad_col_z,
	input  logic signed [31:0] weight,
	output logic done,
	output logic signed [47:0] k_xx,
	output logic signed [47:0] k_xy,
	output logic signed [47:0] k_xz,
	output logic signed [47:0] k_yx,
	output logic signed [47:0] k_yy,
	output logic signed [47:0] k_yz,
	output logic signed [47:0] k_zx,
	output logic signed [47:0] k_zy,
	output logic signed [47:0] k_zz,
	output logic saturated
);
	import eesa_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int DEPTH = MAX_NODES * MAX_NODES * 9;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_G, S_DIAG, S_LAM, S_MU, S_MD, S_CLIP, S_W, S_RD, S_UPD
	} state_t;

	function automatic logic [NW-1:0] node_mod(input logic [3:0] v);
		logic [4:0] t;
		t = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (t >= 5'(MAX_NODES)) t = t - 5'(MAX_NODES);
		end
		return t[NW-1:0];
	endfunction

	state_t state_q;
	logic wait_q, cmd_q, sat_q, done_q;
	logic signed [CFG_W-1:0] lam_q, mu_q, w_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic signed [VAL_W-1:0] g_q [9];
	logic signed [VAL_W-1:0] kout_q [9];
	logic signed [MX_W-1:0] d_q, acc_q;
	logic signed [VAL_W-1:0] t_q, k_q, rd_q;
	logic [1:0] p_q, qi_q;
	logic [AW-1:0] base_q;
	logic [3:0] e, et;
	logic [AW-1:0] addr;
	logic last;
	logic mul_state, mul_start;
	mul_req_t req;
	mul_rsp_t rsp;
	sat_val_t sv_acc, sv_upd;
	logic signed [VAL_W-1:0] upd_val;
	logic signed [VAL_W-1:0] mem [DEPTH];

	eesa_mulq u_mulq (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.req(req),
		.rsp(rsp)
	);

	always_comb begin
		e = 4'(p_q) * 4'd3 + 4'(qi_q);
		et = 4'(qi_q) * 4'd3 + 4'(p_q);
		last = (p_q == 2'd2) && (qi_q == 2'd2);
		addr = base_q + AW'(e);
		mul_state = (state_q == S_G) || (state_q == S_LAM) || (state_q == S_MU) ||
			(state_q == S_MD) || (state_q == S_W);
		mul_start = mul_state && !wait_q;
		req.x = '0;
		req.c = '0;
		unique case (state_q)
			S_G: begin
				req.x = MX_W'(a_q[p_q]);
				req.c = b_q[qi_q];
			end
			S_LAM: begin
				req.x = MX_W'(g_q[e]);
				req.c = lam_q;
			end
			S_MU: begin
				req.x = MX_W'(g_q[et]);
				req.c = mu_q;
			end
			S_MD: begin
				req.x = d_q;
				req.c = mu_q;
			end
			S_W: begin
				req.x = MX_W'(t_q);
				req.c = w_q;
			end
			default: ;
		endcase
		sv_acc = clip48(acc_q);
		sv_upd = clip48(MX_W'(rd_q) + MX_W'(k_q));
		upd_val = cmd_q ? sv_upd.val : k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			done_q <= 1'b0;
			lam_q <= '0;
			mu_q <= '0;
			p_q <= '0;
			qi_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LAMBDA: lam_q <= cfg_data;
					CFG_MU: mu_q <= cfg_data;
					default: ;
				endcase
			end
			if (mul_start) wait_q <= 1'b1;
			else if (rsp.done) wait_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						p_q <= '0;
						qi_q <= '0;
						state_q <= S_G;
					end
				end
				S_G: begin
					if (rsp.done) begin
						qi_q <= (qi_q == 2'd2) ? 2'd0 : qi_q + 2'd1;
						if (qi_q == 2'd2) p_q <= (p_q == 2'd2) ? 2'd0 : p_q + 2'd1;
						if (last) state_q <= S_DIAG;
					end
				end
				S_DIAG: state_q <= S_LAM;
				S_LAM: if (rsp.done) state_q <= S_MU;
				S_MU: if (rsp.done) state_q <= (p_q == qi_q) ? S_MD : S_CLIP;
				S_MD: if (rsp.done) state_q <= S_CLIP;
				S_CLIP: state_q <= S_W;
				S_W: if (rsp.done) state_q <= cmd_q ? S_RD : S_UPD;
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					qi_q <= (qi_q == 2'd2) ? 2'd0 : qi_q + 2'd1;
					if (qi_q == 2'd2) p_q <= (p_q == 2'd2) ? 2'd0 : p_q + 2'd1;
					if (last) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LAM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			sat_q <= 1'b0;
			a_q[0] <= grad_row_x;
			a_q[1] <= grad_row_y;
			a_q[2] <= grad_row_z;
			b_q[0] <= grad_col_x;
			b_q[1] <= grad_col_y;
			b_q[2] <= grad_col_z;
			w_q <= weight;
			base_q <= AW'((int'(node_mod(row_node)) * MAX_NODES +
				int'(node_mod(col_node))) * 9);
		end
		if (rsp.done) begin
			unique case (state_q)
				S_G: g_q[e] <= rsp.val;
				S_LAM: acc_q <= MX_W'(rsp.val);
				S_MU, S_MD: acc_q <= acc_q + MX_W'(rsp.val);
				S_W: k_q <= rsp.val;
				default: ;
			endcase
			if (mul_state) sat_q <= sat_q | rsp.sat;
		end
		if (state_q == S_DIAG) d_q <= MX_W'(g_q[0]) + MX_W'(g_q[4]) + MX_W'(g_q[8]);
		if (state_q == S_CLIP) begin
			t_q <= sv_acc.val;
			sat_q <= sat_q | sv_acc.sat;
		end
		if (state_q == S_UPD) begin
			kout_q[e] <= upd_val;
			if (cmd_q) sat_q <= sat_q | sv_upd.sat;
		end
	end

	// block store
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) mem[addr] <= upd_val;
		if (state_q == S_RD) rd_q <= mem[addr];
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign saturated = sat_q;
	assign k_xx = kout_q[0];
	assign k_xy = kout_q[1];
	assign k_xz = kout_q[2];
	assign k_yx = kout_q[3];
	assign k_yy = kout_q[4];
	assign k_yz = kout_q[5];
	assign k_zx = kout_q[6];
	assign k_zy = kout_q[7];
	assign k_zz = kout_q[8];

endmodule

// ----- sim/eesa_checker.sv -----
// predictor and scoreboard for the element stiffness accumulator
// watches register writes, item transfers and result transfers; depends on eesa_pkg
module eesa_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  eesa_pkg::cfg_idx_t cfg_index,
	input  logic signed [31:0] cfg_data,
	input  logic start,
	input  logic busy,
	input  logic cmd,
	input  logic [3:0] row_node,
	input  logic [3:0] col_node,
	input  logic signed [31:0] grad_row_x,
	input  logic signed [31:0] grad_row_y,
	input  logic signed [31:0] grad_row_z,
	input  logic signed [31:0] grad_col_x,
	input  logic signed [31:0] grad_col_y,
	input  logic signed [31:0] grad_col_z,
	input  logic signed [31:0] weight,
	input  logic done,
	input  logic signed [47:0] k_xx,
	input  logic signed [47:0] k_xy,
	input  logic signed [47:0] k_xz,
	input  logic signed [47:0] k_yx,
	input  logic signed [47:0] k_yy,
	input  logic signed [47:0] k_yz,
	input  logic signed [47:0] k_zx,
	input  logic signed [47:0] k_zy,
	input  logic signed [47:0] k_zz,
	input  logic saturated,
	output int fail_count,
	output int pending
);
	import eesa_pkg::*;

	localparam logic signed [47:0] TOP = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] BOTTOM = -48'sh8000_0000_0000;

	typedef struct {
		logic signed [47:0] k [9];
		logic sat;
	} block_t;

	logic signed [31:0] lambda_reg;
	logic signed [31:0] mu_reg;
	logic signed [47:0] block_store [256][9];
	block_t expected_blocks [$];

	function automatic logic signed [47:0] clamp48(input logic signed [49:0] v, ref logic sat);
		if (v > 50'(TOP)) begin
			sat = 1'b1;
			return TOP;
		end
		if (v < 50'(BOTTOM)) begin
			sat = 1'b1;
			return BOTTOM;
		end
		return v[47:0];
	endfunction

	// product scaled by 2^-16, rounded half away from zero, clamped
	function automatic logic signed [47:0] scale_mul(input logic signed [49:0] x,
			input logic signed [31:0] c, ref logic sat);
		logic signed [81:0] xs;
		logic signed [81:0] cs;
		logic [81:0] mag;
		logic [81:0] q;
		logic neg;
		xs = x;
		cs = c;
		neg = (x < 0) != (c < 0);
		if (xs < 0)
			xs = -xs;
		if (cs < 0)
			cs = -cs;
		mag = xs * cs;
		q = (mag + 82'h8000) >> 16;
		if (neg) begin
			if (q > 82'h8000_0000_0000) begin
				sat = 1'b1;
				return BOTTOM;
			end
			return -q[47:0];
		end
		if (q > 82'h7FFF_FFFF_FFFF) begin
			sat = 1'b1;
			return TOP;
		end
		return q[47:0];
	endfunction

	function automatic block_t predict_block(input logic add, input int idx,
			input logic signed [31:0] a [3], input logic signed [31:0] b [3],
			input logic signed [31:0] w);
		block_t res;
		logic signed [47:0] g [3][3];
		logic signed [49:0] trace;
		logic signed [49:0] sum;
		logic signed [47:0] t;
		logic signed [47:0] kv;
		logic sat;
		sat = 1'b0;
		for (int p = 0; p < 3; p++)
			for (int q = 0; q < 3; q++)
				g[p][q] = scale_mul(50'(a[p]), b[q], sat);
		trace = 50'(g[0][0]) + 50'(g[1][1]) + 50'(g[2][2]);
		for (int p = 0; p < 3; p++) begin
			for (int q = 0; q < 3; q++) begin
				sum = 50'(scale_mul(50'(g[p][q]), lambda_reg, sat))
					+ 50'(scale_mul(50'(g[q][p]), mu_reg, sat));
				if (p == q)
					sum += 50'(scale_mul(trace, mu_reg, sat));
				t = clamp48(sum, sat);
				kv = scale_mul(50'(t), w, sat);
				if (add)
					kv = clamp48(50'(block_store[idx][p*3+q]) + 50'(kv), sat);
				block_store[idx][p*3+q] = kv;
				res.k[p*3+q] = kv;
			end
		end
		res.sat = sat;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic signed [47:0] got [9];
		block_t exp_blk;
		string names [9];
		if (!arst_n) begin
			lambda_reg = '0;
			mu_reg = '0;
			fail_count = 0;
			pending = 0;
			expected_blocks.delete();
		end else begin
			names = '{"k_xx", "k_xy", "k_xz", "k_yx", "k_yy", "k_yz", "k_zx", "k_zy", "k_zz"};
			if (cfg_we) begin
				if (cfg_index == CFG_LAMBDA)
					lambda_reg = cfg_data;
				else
					mu_reg = cfg_data;
			end
			if (start && !busy) begin
				a = '{grad_row_x, grad_row_y, grad_row_z};
				b = '{grad_col_x, grad_col_y, grad_col_z};
				expected_blocks.push_back(predict_block(cmd, {row_node, col_node}, a, b,
					weight));
			end
			if (done) begin
				got = '{k_xx, k_xy, k_xz, k_yx, k_yy, k_yz, k_zx, k_zy, k_zz};
				if (expected_blocks.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					exp_blk = expected_blocks.pop_front();
					for (int i = 0; i < 9; i++)
						if (got[i] !== exp_blk.k[i]) begin
							$error("%s: expected %0d, got %0d", names[i], exp_blk.k[i],
								got[i]);
							fail_count++;
						end
					if (saturated !== exp_blk.sat) begin
						$error("saturated: expected %0d, got %0d", exp_blk.sat, saturated);
						fail_count++;
					end
				end
			end
			pending = expected_blocks.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// top of the element stiffness accumulator testbench: clock, reset, stimulus, verdict
// depends on eesa_pkg, elastic_element_stiffness_accum and eesa_checker
module tb_top;
	import eesa_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic signed [31:0] cfg_data;
	logic start;
	logic busy;
	logic cmd;
	logic [3:0] row_node;
	logic [3:0] col_node;
	logic signed [31:0] grad_row_x, grad_row_y, grad_row_z;
	logic signed [31:0] grad_col_x, grad_col_y, grad_col_z;
	logic signed [31:0] weight;
	logic done;
	logic signed [47:0] k_xx, k_xy, k_xz, k_yx, k_yy, k_yz, k_zx, k_zy, k_zz;
	logic saturated;
	int fail_count;
	int pending;
	int idle_pct;
	bit written [256];

	elastic_element_stiffness_accum DUT (.*);
	eesa_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("elastic_element_stiffness_accum: mismatch");
		$finish;
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
			2: return 32'sd0;
			default: return $signed($urandom_range(0, 1 << 18)) - 32'sd131072;
		endcase
	endfunction

	task automatic send_item(input logic c, input logic [3:0] r, input logic [3:0] cn,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic signed [31:0] bx,
			input logic signed [31:0] by, input logic signed [31:0] bz,
			input logic signed [31:0] w);
		start <= 1'b1;
		cmd <= c;
		row_node <= r;
		col_node <= cn;
		grad_row_x <= ax;
		grad_row_y <= ay;
		grad_row_z <= az;
		grad_col_x <= bx;
		grad_col_y <= by;
		grad_col_z <= bz;
		weight <= w;
		if (!c)
			written[{r, cn}] = 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [3:0] r;
		logic [3:0] cn;
		logic c;
		logic flat;
		r = $urandom_range(0, 15);
		cn = $urandom_range(0, 15);
		c = written[{r, cn}] && ($urandom_range(0, 3) != 0);
		flat = $urandom_range(0, 3) == 0;
		send_item(c, r, cn, pick_value(), pick_value(), flat ? 32'sd0 : pick_value(),
			pick_value(), pick_value(), flat ? 32'sd0 : pick_value(), pick_value());
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic signed [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic signed [31:0] lam_set [6];
		logic signed [31:0] mu_set [6];
		logic signed [31:0] one;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		one = 32'sh0001_0000;
		hi = 32'sh7FFF_FFFF;
		lo = -32'sh8000_0000;
		lam_set = '{32'sh0001_8000, hi, lo, 32'sd0, 32'sd0, 32'sd0};
		mu_set = '{32'sh0000_8000, lo, hi, 32'sd0, 32'sd0, 32'sd0};
		lam_set[4] = pick_value();
		mu_set[4] = pick_value();
		lam_set[5] = $urandom;
		mu_set[5] = $urandom;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LAMBDA;
		cfg_data = '0;
		start = 1'b0;
		cmd = 1'b0;
		row_node = '0;
		col_node = '0;
		grad_row_x = '0;
		grad_row_y = '0;
		grad_row_z = '0;
		grad_col_x = '0;
		grad_col_y = '0;
		grad_col_z = '0;
		weight = '0;
		idle_pct = 37;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero block, extremes, plane use, zero weight, term clipping
		send_item(1'b0, 4'd0, 4'd0, 0, 0, 0, 0, 0, 0, 0);
		send_item(1'b0, 4'd15, 4'd15, one, 2*one, 3*one, -one, one, 2*one, one);
		drain();
		write_cfg(CFG_LAMBDA, lam_set[0]);
		write_cfg(CFG_MU, mu_set[0]);
		send_item(1'b1, 4'd15, 4'd15, one, 2*one, 3*one, -one, one, 2*one, one);
		send_item(1'b0, 4'd3, 4'd7, hi, hi, hi, hi, hi, hi, hi);
		send_item(1'b1, 4'd3, 4'd7, lo, lo, lo, hi, hi, hi, hi);
		send_item(1'b1, 4'd3, 4'd7, lo, lo, lo, hi, hi, hi, hi);
		send_item(1'b0, 4'd1, 4'd2, 3*one, -one, 0, one, 4*one, 0, one/2);
		send_item(1'b1, 4'd1, 4'd2, -one, 5*one, 0, 2*one, -3*one, 0, one);
		send_item(1'b0, 4'd0, 4'd15, hi, lo, hi, lo, hi, lo, 0);
		send_item(1'b0, 4'd15, 4'd0, lo, lo, lo, lo, lo, lo, lo);
		send_item(1'b1, 4'd15, 4'd0, lo, lo, lo, lo, lo, lo, lo);
		send_item(1'b0, 4'd8, 4'd9, 32'sh0100_0000, 32'sh0100_0000, 0,
			32'sh0100_0000, -32'sh0100_0000, 0, one);
		send_item(1'b1, 4'd8, 4'd9, 1, -1, 1, -1, 1, -1, hi);

		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = ph < 2 ? 37 : (ph < 4 ? 81 : 0);
			drain();
			write_cfg(CFG_LAMBDA, lam_set[ph]);
			write_cfg(CFG_MU, mu_set[ph]);
			for (int i = 0; i < 140; i++)
				send_random();
		end

		start <= 1'b0;
		@(negedge clk);
		for (int n = 0; n < 5000 && pending != 0; n++)
			@(negedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("elastic_element_stiffness_accum: match");
		else
			$display("elastic_element_stiffness_accum: mismatch");
		$finish;
	end

endmodule
